[src/lee_pkg.sv]
// Shared types and constants for the line editor with erase and kill.
// Used by the front end, the command queue and the back end.
`default_nettype none
package lee_pkg;

  localparam int LEE_DEPTH  = 64;
  localparam int LEE_QDEPTH = 2;

  localparam logic [7:0] ERASE_CHAR_RST = 8'd35;
  localparam logic [7:0] KILL_CHAR_RST  = 8'd64;
  localparam logic [7:0] END_CHAR_RST   = 8'd10;

  localparam logic [1:0] CFG_ERASE = 2'd0;
  localparam logic [1:0] CFG_KILL  = 2'd1;
  localparam logic [1:0] CFG_END   = 2'd2;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_ERASE = 2'd1,
    KIND_KILL  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_e;

endpackage
`default_nettype wire

[src/lee_front.sv]
// Front end: configuration registers and byte classification.
// Depends on lee_pkg for the command type and register indexes.
`default_nettype none
module lee_front import lee_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  logic [7:0] erase_q, kill_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      erase_q <= ERASE_CHAR_RST;
      kill_q  <= KILL_CHAR_RST;
      end_q   <= END_CHAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ERASE: erase_q <= cfg_data_i;
        CFG_KILL:  kill_q  <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The end code takes priority, then erase, then kill.
  always_comb begin
    cmd_o.data = in_byte_i;
    if (in_byte_i == end_q) begin
      cmd_o.kind = KIND_END;
    end else if (in_byte_i == erase_q) begin
      cmd_o.kind = KIND_ERASE;
    end else if (in_byte_i == kill_q) begin
      cmd_o.kind = KIND_KILL;
    end else begin
      cmd_o.kind = KIND_CHAR;
    end
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule
`default_nettype wire

[src/lee_queue.sv]
// Short command queue between the front end and the back end.
// Depends on lee_pkg for the command type and queue depth.
`default_nettype none
module lee_queue import lee_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_cmd_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_cmd_o
);

  localparam int PW = (LEE_QDEPTH > 1) ? $clog2(LEE_QDEPTH) : 1;
  localparam int CW = $clog2(LEE_QDEPTH + 1);

  cmd_t          entry_q [LEE_QDEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(LEE_QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PW'(LEE_QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PW'(LEE_QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

[src/lee_back.sv]
// Back end: line buffer memory, fill count, drain sequencer and output register.
// Depends on lee_pkg for the command type and state encoding.
`default_nettype none
module lee_back import lee_pkg::*; #(
  parameter int DEPTH = LEE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  output logic            cmd_ready_o,
  input  cmd_t            cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_line_o,
  output logic            empty_line_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_q [DEPTH];
  logic [7:0]    rd_data_q;
  back_state_e   state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, rd_idx_q, rd_idx_d;
  logic          pend_q, pend_last_q, pend_empty_q;
  logic          out_valid_q, out_last_q, out_empty_q;
  logic [7:0]    out_byte_q;
  logic          pend_adv, can_issue, drain_issue, empty_issue, wr_en, rd_last, idle;

  assign idle        = (state_q == ST_IDLE);
  assign pend_adv    = pend_q && (!out_valid_q || out_ready_i);
  assign can_issue   = !pend_q || pend_adv;
  assign rd_last     = ((rd_idx_q + CW'(1)) == cnt_q);
  assign drain_issue = (state_q == ST_DRAIN) && can_issue;
  assign empty_issue = idle && cmd_valid_i && (cmd_i.kind == KIND_END)
                       && (cnt_q == '0) && can_issue;
  assign wr_en       = idle && cmd_valid_i && (cmd_i.kind == KIND_CHAR)
                       && (cnt_q < CW'(DEPTH));

  always_comb begin
    cmd_ready_o = 1'b0;
    if (idle) begin
      if (cmd_i.kind != KIND_END || cnt_q != '0) begin
        cmd_ready_o = 1'b1;
      end else begin
        cmd_ready_o = can_issue;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            KIND_CHAR: begin
              if (wr_en) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            KIND_ERASE: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            KIND_KILL: cnt_d = '0;
            KIND_END: begin
              if (cnt_q != '0) begin
                state_d  = ST_DRAIN;
                rd_idx_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (drain_issue) begin
          if (rd_last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      if (drain_issue || empty_issue) begin
        pend_q <= 1'b1;
      end else if (pend_adv) begin
        pend_q <= 1'b0;
      end
      if (pend_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_issue || empty_issue) begin
      pend_last_q  <= empty_issue || rd_last;
      pend_empty_q <= empty_issue;
    end
    if (pend_adv) begin
      out_byte_q  <= pend_empty_q ? 8'd0 : rd_data_q;
      out_last_q  <= pend_last_q;
      out_empty_q <= pend_empty_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= cmd_i.data;
    end
    if (drain_issue) begin
      rd_data_q <= mem_q[rd_idx_q[AW-1:0]];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_of_line_o = out_last_q;
  assign empty_line_o   = out_empty_q;

endmodule
`default_nettype wire

[src/line_editor_erase_kill.sv]
// Top level of the line editor with erase and kill codes.
// Depends on lee_pkg, lee_front, lee_queue and lee_back.
//
//   Channel  Handshake              Payload
//   input    in_valid_i/in_ready_o  in_byte_i
//   output   out_valid_o/out_ready_i out_byte_o, last_of_line_o, empty_line_o
//   config   cfg_we_i               cfg_idx_i, cfg_data_i
//
// Ordinary, erase and kill bytes are taken by the back end whenever it is idle.
// A line end with buffered bytes holds the back end in its drain state until each
// byte is read out, through the read data and pending registers to the output.
// Input stalls only once the two-entry command queue is full.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none
module line_editor_erase_kill import lee_pkg::*; #(
  parameter int DEPTH = LEE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_of_line_o,
  output logic            empty_line_o
);

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  lee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  lee_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_cmd_i  (front_cmd),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready),
    .pop_cmd_o   (back_cmd)
  );

  lee_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (back_valid),
    .cmd_ready_o   (back_ready),
    .cmd_i         (back_cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_line_o(last_of_line_o),
    .empty_line_o  (empty_line_o)
  );

endmodule
`default_nettype wire

[src/lee_checker.sv]
// Port-level checks for the line editor, bound to the top level.
// Depends only on the ports of line_editor_erase_kill.
`default_nettype none
module lee_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       last_of_line_i,
  input wire logic       empty_line_i
);

  // An empty line is a single item that closes the line and carries a zero byte.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_line_i |-> last_of_line_i && (out_byte_i == 8'd0))
    else $error("empty-line item is not a zero last item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_byte_i) && $stable(last_of_line_i) && $stable(empty_line_i))
    else $error("output payload changed while stalled");

endmodule

bind line_editor_erase_kill lee_checker u_lee_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_byte_i    (out_byte_o),
  .last_of_line_i(last_of_line_o),
  .empty_line_i  (empty_line_o)
);
`default_nettype wire

[test/line_editor_erase_kill_chk.sv]
// Checker for the line editor: follows the configuration and input transfers,
// predicts each output transfer and compares it field by field.
// Depends on lee_pkg for the register indexes, reset codes and buffer depth.
module line_editor_erase_kill_chk import lee_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_of_line_i,
  input  logic       empty_line_i,
  output int         pending_o,
  output int         errors_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       blank;
  } line_char_t;

  line_char_t line_q[$];
  logic [7:0] held_chars [LEE_DEPTH];
  logic [6:0] held_cnt   = '0;
  logic [7:0] erase_code = ERASE_CHAR_RST;
  logic [7:0] kill_code  = KILL_CHAR_RST;
  logic [7:0] end_code   = END_CHAR_RST;
  int         errors     = 0;

  task automatic edit_line(input logic [7:0] b);
    line_char_t res;
    if (b == end_code) begin
      if (held_cnt == 0) begin
        res = '{ch: 8'd0, eol: 1'b1, blank: 1'b1};
        line_q.push_back(res);
      end else begin
        for (int k = 0; k < held_cnt; k++) begin
          res = '{ch: held_chars[k], eol: (k == held_cnt - 1), blank: 1'b0};
          line_q.push_back(res);
        end
        held_cnt = '0;
      end
    end else if (b == erase_code) begin
      if (held_cnt != 0) held_cnt = held_cnt - 7'd1;
    end else if (b == kill_code) begin
      held_cnt = '0;
    end else if (held_cnt < LEE_DEPTH) begin
      held_chars[held_cnt] = b;
      held_cnt = held_cnt + 7'd1;
    end
  endtask

  task automatic check_result();
    line_char_t want;
    if (line_q.size() == 0) begin
      $error("output transfer with nothing expected: out_byte %0h", out_byte_i);
      errors++;
    end else begin
      want = line_q.pop_front();
      if (out_byte_i !== want.ch) begin
        $error("out_byte: expected %0h, actual %0h", want.ch, out_byte_i);
        errors++;
      end
      if (last_of_line_i !== want.eol) begin
        $error("last_of_line: expected %0b, actual %0b", want.eol, last_of_line_i);
        errors++;
      end
      if (empty_line_i !== want.blank) begin
        $error("empty_line: expected %0b, actual %0b", want.blank, empty_line_i);
        errors++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt   = '0;
      erase_code = ERASE_CHAR_RST;
      kill_code  = KILL_CHAR_RST;
      end_code   = END_CHAR_RST;
      line_q.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_ready_i === 1'b1) check_result();
      if (cfg_we_i === 1'b1) begin
        case (cfg_idx_i)
          CFG_ERASE: erase_code = cfg_data_i;
          CFG_KILL:  kill_code  = cfg_data_i;
          CFG_END:   end_code   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i === 1'b1 && in_ready_i === 1'b1) edit_line(in_byte_i);
    end
    pending_o <= line_q.size();
    errors_o  <= errors;
  end

endmodule

[test/line_editor_erase_kill_tb.sv]
// Top of the line editor testbench: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on lee_pkg, line_editor_erase_kill and
// line_editor_erase_kill_chk.
module line_editor_erase_kill_tb;
  import lee_pkg::*;

  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       cfg_we_i   = 1'b0;
  logic [1:0] cfg_idx_i  = CFG_ERASE;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i  = '0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_of_line_o;
  logic       empty_line_o;

  int pending;
  int errors;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;
  int sent      = 0;

  logic [7:0] erase_code = ERASE_CHAR_RST;
  logic [7:0] kill_code  = KILL_CHAR_RST;
  logic [7:0] end_code   = END_CHAR_RST;

  line_editor_erase_kill u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_byte_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .last_of_line_o,
    .empty_line_o
  );

  line_editor_erase_kill_chk u_chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .in_byte_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .out_byte_i     (out_byte_o),
    .last_of_line_i (last_of_line_o),
    .empty_line_i   (empty_line_o),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] plain_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch == erase_code || ch == kill_code || ch == end_code);
    return ch;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    sent++;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic send_line(input int max_len);
    int len;
    int r;
    len = ($urandom_range(9) == 0) ? $urandom_range(max_len) : $urandom_range(8);
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 10) send_byte(erase_code);
      else if (r < 14) send_byte(kill_code);
      else send_byte(plain_byte());
    end
    send_byte(end_code);
  endtask

  task automatic run_random(input int quota);
    int first;
    first = sent;
    while (sent - first < quota) begin
      if ($urandom_range(99) < 20) send_byte(8'($urandom_range(255)));
      else send_line(70);
    end
  endtask

  // Waits until every predicted result has been taken, then lets the
  // command queue and back end run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_ERASE: erase_code = data;
      CFG_KILL:  kill_code  = data;
      CFG_END:   end_code   = data;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] er, input logic [7:0] kl, input logic [7:0] en);
    write_reg(CFG_ERASE, er);
    write_reg(CFG_KILL, kl);
    write_reg(CFG_END, en);
    cfg_we_i <= 1'b0;
  endtask

  // The receiver runs on its own; a long hold-off is requested by bumping hold_seq.
  initial begin : receiver
    int seen_hold;
    seen_hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) === 1'b1 || (out_valid_o && out_ready_i) === 1'b1)
        quiet = 0;
      else
        quiet++;
    end
    $display("line_editor_erase_kill test failed");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset codes: empty line, extreme bytes,
    // erase on an empty buffer, erase and kill inside a line.
    send_byte(end_code);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(end_code);
    send_byte(erase_code);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(erase_code);
    send_byte(end_code);
    send_byte(8'h78);
    send_byte(8'h79);
    send_byte(kill_code);
    send_byte(8'h7A);
    send_byte(end_code);
    send_byte(kill_code);
    send_byte(end_code);
    run_random(14);
    settle();

    // Unused register index must be ignored.
    write_reg(CFG_NONE, 8'h20);
    set_codes(8'h00, 8'hFF, 8'h0D);
    idle_pct = 64;
    run_random(14);
    settle();

    // Erase and kill share a code, so erase wins.
    set_codes(8'h7F, 8'h7F, 8'h00);
    idle_pct  = 0;
    stall_pct = 64;
    run_random(14);
    settle();

    // Erase and end share a code, so end wins.
    set_codes(8'hFF, 8'h15, 8'hFF);
    idle_pct  = 26;
    stall_pct = 26;
    run_random(14);
    settle();

    // Kill and end share a code. The receiver holds off while a line longer
    // than the buffer arrives, so the buffer overflows; the held output then stalls the drain and the input.
    set_codes(8'h08, 8'h40, 8'h40);
    idle_pct  = 0;
    stall_pct = 0;
    hold_seq++;
    for (int k = 0; k < LEE_DEPTH + 2; k++) send_byte(plain_byte());
    send_byte(end_code);
    run_random(8);
    settle();

    if (errors == 0)
      $display("line_editor_erase_kill test passed");
    else
      $display("line_editor_erase_kill test failed");
    $finish;
  end

endmodule

[line_editor_erase_kill.f]
src/lee_pkg.sv
src/lee_front.sv
src/lee_queue.sv
src/lee_back.sv
src/line_editor_erase_kill.sv
src/lee_checker.sv
test/line_editor_erase_kill_chk.sv
test/line_editor_erase_kill_tb.sv
